// ===== rtl/core/lvsg_pkg.sv =====
// ============================================================================
// lvsg_pkg : shared types and constants of the lead vehicle speed governor
// Field widths, stream packing offsets, register codes, datapath commands,
// controller states and reset values of the governor.
// ============================================================================
package lvsg_pkg;

    // field widths of the stream items and registers
    localparam int POS_W  = 22;    // longitudinal positions and gaps
    localparam int LAT_W  = 14;    // lateral offsets
    localparam int VEL_W  = 16;    // velocity components
    localparam int HOR_W  = 6;     // horizon points
    localparam int SPD_W  = 16;    // speeds on the ports and in registers
    localparam int STEP_W = 12;    // speed step register

    // configuration port
    localparam int CFG_W     = 22;
    localparam int CFG_IDX_W = 3;

    // input tdata packing, lowest field first
    localparam int OFS_VS  = 0;
    localparam int OFS_VD  = OFS_VS + POS_W;
    localparam int OFS_VX  = OFS_VD + LAT_W;
    localparam int OFS_VY  = OFS_VX + VEL_W;
    localparam int OFS_ES  = OFS_VY + VEL_W;
    localparam int OFS_ED  = OFS_ES + POS_W;
    localparam int OFS_HOR = OFS_ED + LAT_W;
    localparam int IN_BITS = OFS_HOR + HOR_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

    // output tdata packing: ego_speed, lead_gap, lead_speed
    localparam int OUT_BITS   = SPD_W + POS_W + SPD_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;

    // parameter defaults
    localparam int DEF_POSITION_BITS = 22;
    localparam int DEF_SPEED_BITS    = 16;
    localparam int DEF_HORIZON_MAX   = 63;

    // arithmetic constants
    localparam longint unsigned SENTINEL_GAP = 64'd256000;  // 1000 m
    localparam int DIV_PTS         = 50;                    // points per second
    localparam int DIV_PTS_LOG2    = $clog2(DIV_PTS);
    localparam int SQ_W            = 2 * VEL_W;             // vx*vx + vy*vy
    localparam int ROOT_W          = VEL_W;
    localparam int ROOT_STEPS      = SQ_W / 2;
    localparam int ITER_W          = $clog2(ROOT_STEPS);
    localparam int RATIO_NUM_CATCH = 9;                     // 0.90 of lead speed
    localparam int RATIO_DEN_CATCH = 10;
    localparam int RATIO_NUM_LIMIT = 99;                    // 0.99 of limit
    localparam int RATIO_DEN_LIMIT = 100;

    // register reset values
    localparam logic [POS_W-1:0]  RST_ROAD_LENGTH   = 22'd1778062;
    localparam logic [SPD_W-1:0]  RST_SPEED_LIMIT   = 16'd5632;
    localparam logic [SPD_W-1:0]  RST_MIN_SPEED     = 16'd0;
    localparam logic [LAT_W-1:0]  RST_LANE_HALF     = 14'd512;
    localparam logic [POS_W-1:0]  RST_TOO_CLOSE_GAP = 22'd6400;
    localparam logic [POS_W-1:0]  RST_CATCH_NEAR    = 22'd7680;
    localparam logic [POS_W-1:0]  RST_CATCH_FAR     = 22'd12800;
    localparam logic [STEP_W-1:0] RST_SPEED_STEP    = 12'd57;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROAD_LENGTH   = 3'd0,
        CFG_SPEED_LIMIT   = 3'd1,
        CFG_MIN_SPEED     = 3'd2,
        CFG_LANE_HALF     = 3'd3,
        CFG_TOO_CLOSE_GAP = 3'd4,
        CFG_CATCH_NEAR    = 3'd5,
        CFG_CATCH_FAR     = 3'd6,
        CFG_SPEED_STEP    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [POS_W-1:0]  road_length;
        logic [SPD_W-1:0]  speed_limit;
        logic [SPD_W-1:0]  min_speed;
        logic [LAT_W-1:0]  lane_half_width;
        logic [POS_W-1:0]  too_close_gap;
        logic [POS_W-1:0]  catch_up_near;
        logic [POS_W-1:0]  catch_up_far;
        logic [STEP_W-1:0] speed_step;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0]        vehicle_s;
        logic [LAT_W-1:0]        vehicle_d;
        logic signed [VEL_W-1:0] vehicle_vx;
        logic signed [VEL_W-1:0] vehicle_vy;
        logic [POS_W-1:0]        ego_s;
        logic [LAT_W-1:0]        ego_d;
        logic [HOR_W-1:0]        horizon_points;
        logic                    is_vehicle;
        logic                    last_in_frame;
    } t_item;

    typedef struct packed {
        logic [SPD_W-1:0] ego_speed;
        logic             too_close;
        logic [POS_W-1:0] lead_gap;
        logic [SPD_W-1:0] lead_speed;
        logic             lead_found;
    } t_result;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_SQUARE,
        DP_ROOT_INIT,
        DP_ROOT_STEP,
        DP_MUL_V,
        DP_DIV_V,
        DP_MUL_E,
        DP_DIV_E,
        DP_GAP,
        DP_WRAP_HI,
        DP_WRAP_LO,
        DP_KEEP,
        DP_FRAME
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_cmd;

    typedef struct packed {
        logic is_vehicle;
        logic last;
        logic in_lane;
        logic out_free;
    } t_sts;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_MUL_V,
        ST_DIV_V,
        ST_MUL_E,
        ST_DIV_E,
        ST_GAP,
        ST_WRAP_HI,
        ST_WRAP_LO,
        ST_KEEP,
        ST_FRAME
    } t_state;

endpackage

// ===== rtl/core/lvsg_cfg.sv =====
// ============================================================================
// lvsg_cfg : configuration registers
// Eight write-only registers, loaded from the plain write port by index.
// ============================================================================
module lvsg_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [lvsg_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [lvsg_pkg::CFG_W-1:0]     i_wdata,
    output lvsg_pkg::t_cfg                 o_cfg
);
    import lvsg_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.road_length     <= RST_ROAD_LENGTH;
            r_cfg.speed_limit     <= RST_SPEED_LIMIT;
            r_cfg.min_speed       <= RST_MIN_SPEED;
            r_cfg.lane_half_width <= RST_LANE_HALF;
            r_cfg.too_close_gap   <= RST_TOO_CLOSE_GAP;
            r_cfg.catch_up_near   <= RST_CATCH_NEAR;
            r_cfg.catch_up_far    <= RST_CATCH_FAR;
            r_cfg.speed_step      <= RST_SPEED_STEP;
        end else if (i_we) begin
            unique case (t_cfg_idx'(i_index))
                CFG_ROAD_LENGTH:   r_cfg.road_length     <= i_wdata[POS_W-1:0];
                CFG_SPEED_LIMIT:   r_cfg.speed_limit     <= i_wdata[SPD_W-1:0];
                CFG_MIN_SPEED:     r_cfg.min_speed       <= i_wdata[SPD_W-1:0];
                CFG_LANE_HALF:     r_cfg.lane_half_width <= i_wdata[LAT_W-1:0];
                CFG_TOO_CLOSE_GAP: r_cfg.too_close_gap   <= i_wdata[POS_W-1:0];
                CFG_CATCH_NEAR:    r_cfg.catch_up_near   <= i_wdata[POS_W-1:0];
                CFG_CATCH_FAR:     r_cfg.catch_up_far    <= i_wdata[POS_W-1:0];
                CFG_SPEED_STEP:    r_cfg.speed_step      <= i_wdata[STEP_W-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/lvsg_ctrl.sv =====
// ============================================================================
// lvsg_ctrl : sequencing controller
// Steps the datapath through square, root iterations, projection, gap wrap
// and frame close, one command per cycle unless the frame close must wait.
// ============================================================================
module lvsg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lvsg_pkg::t_sts i_sts,
    output lvsg_pkg::t_cmd o_cmd
);
    import lvsg_pkg::*;

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ROOT_STEPS - 1);

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_valid) n_state = ST_CHECK;
            ST_CHECK: begin
                priority if (i_sts.is_vehicle && i_sts.in_lane) n_state = ST_ROOT_INIT;
                else if (i_sts.last)                              n_state = ST_FRAME;
                else                                              n_state = ST_IDLE;
            end
            ST_ROOT_INIT: n_state = ST_ROOT;
            ST_ROOT:      if (r_iter == ITER_LAST) n_state = ST_MUL_V;
            ST_MUL_V:     n_state = ST_DIV_V;
            ST_DIV_V:     n_state = ST_MUL_E;
            ST_MUL_E:     n_state = ST_DIV_E;
            ST_DIV_E:     n_state = ST_GAP;
            ST_GAP:       n_state = ST_WRAP_HI;
            ST_WRAP_HI:   n_state = ST_WRAP_LO;
            ST_WRAP_LO:   n_state = ST_KEEP;
            ST_KEEP:      n_state = i_sts.last ? ST_FRAME : ST_IDLE;
            // hold until the previous result has been transferred
            ST_FRAME:     if (i_sts.out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // root iteration counter
    always_comb begin
        n_iter = r_iter;
        unique case (r_state)
            ST_ROOT_INIT: n_iter = '0;
            ST_ROOT:      n_iter = r_iter + ITER_W'(1);
            default:      n_iter = r_iter;
        endcase
    end

    // outputs
    always_comb begin
        o_ready   = 1'b0;
        o_cmd.op  = DP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                o_ready  = 1'b1;
                o_cmd.op = i_valid ? DP_LOAD : DP_NONE;
            end
            ST_CHECK:     o_cmd.op = DP_SQUARE;
            ST_ROOT_INIT: o_cmd.op = DP_ROOT_INIT;
            ST_ROOT:      o_cmd.op = DP_ROOT_STEP;
            ST_MUL_V:     o_cmd.op = DP_MUL_V;
            ST_DIV_V:     o_cmd.op = DP_DIV_V;
            ST_MUL_E:     o_cmd.op = DP_MUL_E;
            ST_DIV_E:     o_cmd.op = DP_DIV_E;
            ST_GAP:       o_cmd.op = DP_GAP;
            ST_WRAP_HI:   o_cmd.op = DP_WRAP_HI;
            ST_WRAP_LO:   o_cmd.op = DP_WRAP_LO;
            ST_KEEP:      o_cmd.op = DP_KEEP;
            ST_FRAME:     o_cmd.op = i_sts.out_free ? DP_FRAME : DP_NONE;
            default:      o_cmd.op = DP_NONE;
        endcase
    end

endmodule

// ===== rtl/core/lvsg_dp.sv =====
// ============================================================================
// lvsg_dp : governor datapath
// Item register, squares, bit-pair square root, projection by multiply and
// reciprocal, gap wrap, nearest-lead tracking, speed step and result register.
// ============================================================================
module lvsg_dp #(
    parameter int POSITION_BITS = lvsg_pkg::DEF_POSITION_BITS,
    parameter int SPEED_BITS    = lvsg_pkg::DEF_SPEED_BITS,
    parameter int HORIZON_MAX   = lvsg_pkg::DEF_HORIZON_MAX
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lvsg_pkg::t_cfg    i_cfg,
    input  lvsg_pkg::t_item   i_item,
    input  lvsg_pkg::t_cmd    i_cmd,
    output lvsg_pkg::t_sts    o_sts,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output lvsg_pkg::t_result o_res
);
    import lvsg_pkg::*;

    localparam int PW  = POSITION_BITS;
    localparam int SW  = SPEED_BITS;
    localparam int MW  = (SW > SPD_W) ? SW : SPD_W;          // multiplier speed operand
    localparam int NW  = HOR_W + MW;                         // h * speed
    localparam int KSH = NW + DIV_PTS_LOG2;                  // reciprocal shift
    localparam logic [NW:0] MREC =
        (NW+1)'(((64'd1 << KSH) + 64'(DIV_PTS) - 64'd1) / 64'(DIV_PTS));
    localparam int AW  = NW - (DIV_PTS_LOG2 - 1);            // advance width
    localparam int XW  = (PW > AW) ? PW : AW;
    localparam int GW  = ((XW > POS_W) ? XW : POS_W) + 2;    // signed gap
    localparam int CW  = (PW > POS_W) ? PW : POS_W;          // gap compares
    localparam int EW  = MW + 1;                             // speed arithmetic
    localparam int TW  = EW + 7;                             // scaled speed compares

    localparam longint unsigned POS_MAX = (64'd1 << PW) - 64'd1;
    localparam logic [PW-1:0] GAP_SENT =
        PW'((SENTINEL_GAP > POS_MAX) ? POS_MAX : SENTINEL_GAP);
    localparam logic [SW-1:0] SPD_ALL = '1;

    // item and working registers
    t_item                   r_item;
    logic [SQ_W-1:0]         r_sqx, r_sqy;
    logic [SQ_W-1:0]         r_rem, r_root, r_bit;
    logic [SW-1:0]           r_spd;
    logic [NW-1:0]           r_prod;
    logic [AW-1:0]           r_advv, r_adve;
    logic signed [GW-1:0]    r_gap;
    // frame state
    logic [PW-1:0]           r_ngap;
    logic [SW-1:0]           r_nspeed;
    logic                    r_found;
    logic [SPD_W-1:0]        r_cur;
    // result
    t_result                 r_res;
    logic                    r_res_valid;

    // lane test
    logic [LAT_W-1:0] dd;
    assign dd = (r_item.vehicle_d >= r_item.ego_d) ? r_item.vehicle_d - r_item.ego_d
                                                    : r_item.ego_d - r_item.vehicle_d;

    assign o_sts.is_vehicle = r_item.is_vehicle;
    assign o_sts.last       = r_item.last_in_frame;
    assign o_sts.in_lane    = dd < i_cfg.lane_half_width;
    assign o_sts.out_free   = !r_res_valid || i_res_ready;

    // squares
    logic signed [SQ_W-1:0] sqx_full, sqy_full;
    assign sqx_full = r_item.vehicle_vx * r_item.vehicle_vx;
    assign sqy_full = r_item.vehicle_vy * r_item.vehicle_vy;

    // one root bit per step
    logic [SQ_W:0] trial;
    logic          take;
    assign trial = {1'b0, r_root} + {1'b0, r_bit};
    assign take  = {1'b0, r_rem} >= trial;

    // speed saturation and projection products
    logic [MW-1:0]    root_m, spd_sat;
    logic [HOR_W-1:0] h_sat;
    logic [NW-1:0]    prod_v, prod_e;
    logic [2*NW:0]    dprod;
    assign root_m  = MW'(r_root[ROOT_W-1:0]);
    assign spd_sat = (root_m > MW'(SPD_ALL)) ? MW'(SPD_ALL) : root_m;
    assign h_sat   = (int'(r_item.horizon_points) > HORIZON_MAX) ? HOR_W'(HORIZON_MAX)
                                                                  : r_item.horizon_points;
    assign prod_v  = NW'(h_sat) * NW'(spd_sat);
    assign prod_e  = NW'(h_sat) * NW'(r_cur);
    assign dprod   = (2*NW+1)'(r_prod) * (2*NW+1)'(MREC);

    // gap and wrap
    logic signed [GW-1:0] gap_raw, len_g;
    logic signed [GW:0]   gap2, len2;
    logic                 keep;
    assign gap_raw = $signed(GW'(PW'(r_item.vehicle_s))) + $signed(GW'(r_advv))
                   - $signed(GW'(PW'(r_item.ego_s)))     - $signed(GW'(r_adve));
    assign len_g   = $signed(GW'(i_cfg.road_length));
    assign len2    = $signed((GW+1)'(i_cfg.road_length));
    assign gap2    = {r_gap, 1'b0};
    assign keep    = (r_gap > 0) && (r_gap < $signed(GW'(r_ngap)));

    // frame close: brake, catch up, cruise toward the limit or hold the speed
    logic [CW-1:0] g_n, g_tc, g_near, g_far;
    logic [EW-1:0] s_e, step_e, ns_e, lim_e, min_e, dec, s_up, s_new;
    logic          close, catch_up, cruise;
    assign g_n    = CW'(r_ngap);
    assign g_tc   = CW'(i_cfg.too_close_gap);
    assign g_near = CW'(i_cfg.catch_up_near);
    assign g_far  = CW'(i_cfg.catch_up_far);
    assign s_e    = EW'(r_cur);
    assign step_e = EW'(i_cfg.speed_step);
    assign ns_e   = EW'(r_nspeed);
    assign lim_e  = EW'(i_cfg.speed_limit);
    assign min_e  = EW'(i_cfg.min_speed);
    assign s_up   = s_e + step_e;

    always_comb begin
        close    = r_found && (g_n < g_tc);
        dec      = (s_e > step_e) ? s_e - step_e : '0;
        if (dec < min_e) dec = min_e;
        catch_up = (g_near < g_n) && (g_n < g_far)
                && (TW'(s_e) * TW'(RATIO_DEN_CATCH) < TW'(ns_e) * TW'(RATIO_NUM_CATCH));
        cruise   = (g_n > g_far)
                && (TW'(s_e) * TW'(RATIO_DEN_LIMIT) < TW'(lim_e) * TW'(RATIO_NUM_LIMIT));
        priority if (close)    s_new = dec;
        else if (catch_up)     s_new = (s_up > ns_e) ? ns_e : s_up;
        else if (cruise)       s_new = (s_up > lim_e) ? lim_e : s_up;
        else                   s_new = s_e;
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LOAD:   r_item <= i_item;
            DP_SQUARE: begin
                r_sqx <= unsigned'(sqx_full);
                r_sqy <= unsigned'(sqy_full);
            end
            DP_ROOT_INIT: begin
                r_rem  <= r_sqx + r_sqy;
                r_root <= '0;
                r_bit  <= SQ_W'(1) << (SQ_W - 2);
            end
            DP_ROOT_STEP: begin
                if (take) begin
                    r_rem  <= r_rem - trial[SQ_W-1:0];
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            DP_MUL_V: begin
                r_spd  <= SW'(spd_sat);
                r_prod <= prod_v;
            end
            DP_DIV_V:  r_advv <= AW'(dprod >> KSH);
            DP_MUL_E:  r_prod <= prod_e;
            DP_DIV_E:  r_adve <= AW'(dprod >> KSH);
            DP_GAP:    r_gap  <= gap_raw;
            DP_WRAP_HI: if (gap2 > len2)  r_gap <= r_gap - len_g;
            DP_WRAP_LO: if (gap2 < -len2) r_gap <= r_gap + len_g;
            DP_FRAME: begin
                r_res.ego_speed  <= SPD_W'(s_new);
                r_res.too_close  <= close;
                r_res.lead_gap   <= POS_W'(r_ngap);
                r_res.lead_speed <= SPD_W'(r_nspeed);
                r_res.lead_found <= r_found;
            end
            default: ;
        endcase
    end

    // frame state and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ngap      <= GAP_SENT;
            r_nspeed    <= SPD_ALL;
            r_found     <= 1'b0;
            r_cur       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                DP_KEEP: begin
                    if (keep) begin
                        r_ngap   <= PW'(r_gap);
                        r_nspeed <= r_spd;
                        r_found  <= 1'b1;
                    end
                end
                DP_FRAME: begin
                    r_cur    <= SPD_W'(s_new);
                    r_ngap   <= GAP_SENT;
                    r_nspeed <= SPD_ALL;
                    r_found  <= 1'b0;
                end
                default: ;
            endcase
            if (i_cmd.op == DP_FRAME) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

`ifndef SYNTHESIS
    a_no_lead_is_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_found |-> (r_ngap == GAP_SENT) && (r_nspeed == SPD_ALL))
        else $error("frame state without a lead is not at its sentinel");

    a_frame_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_FRAME) |-> o_sts.out_free)
        else $error("frame closed while the result register was occupied");

    a_result_from_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_res_valid) |-> $past(i_cmd.op == DP_FRAME))
        else $error("result appeared without a frame close");

    a_close_needs_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> (!r_res.too_close || r_res.lead_found))
        else $error("too_close reported without a lead");
`endif

endmodule

// ===== rtl/core/lead_vehicle_speed_governor.sv =====
// ============================================================================
// lead_vehicle_speed_governor : lead vehicle selection and ego speed stepping
// Picks the nearest same-lane vehicle ahead of each sensor frame and steps
// the ego speed once per frame.
// ============================================================================
// A vehicle item inside the lane holds off the next input until it is through
// its steps: square, root set-up, sixteen steps of the bit-pair square root,
// the vehicle and ego projections, each a product and then a multiply by the
// shared reciprocal, then gap, wrap above, wrap below and the nearest-lead
// update. Marker items and vehicles outside the lane stop after the lane
// check. The last item of a frame adds a step to step the ego speed and load
// the result register, and holds there while the previous result has not
// yet been transferred. There is no clearing pass after reset.
module lead_vehicle_speed_governor #(
    parameter int POSITION_BITS = lvsg_pkg::DEF_POSITION_BITS,
    parameter int SPEED_BITS    = lvsg_pkg::DEF_SPEED_BITS,
    parameter int HORIZON_MAX   = lvsg_pkg::DEF_HORIZON_MAX
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [lvsg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lvsg_pkg::CFG_W-1:0]      i_cfg_wdata,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // vehicle_s, vehicle_d, vehicle_vx, vehicle_vy, ego_s, ego_d, horizon_points
    input  logic [lvsg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // is_vehicle
    input  logic                            s_axis_tuser,
    // last_in_frame
    input  logic                            s_axis_tlast,
    // output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // ego_speed, lead_gap, lead_speed
    output logic [lvsg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // too_close, lead_found
    output logic [lvsg_pkg::OUT_USER_W-1:0] m_axis_tuser
);
    import lvsg_pkg::*;

    t_cfg    cfg;
    t_item   item;
    t_cmd    cmd;
    t_sts    sts;
    t_result res;

    assign item.vehicle_s      = s_axis_tdata[OFS_VS  +: POS_W];
    assign item.vehicle_d      = s_axis_tdata[OFS_VD  +: LAT_W];
    assign item.vehicle_vx     = s_axis_tdata[OFS_VX  +: VEL_W];
    assign item.vehicle_vy     = s_axis_tdata[OFS_VY  +: VEL_W];
    assign item.ego_s          = s_axis_tdata[OFS_ES  +: POS_W];
    assign item.ego_d          = s_axis_tdata[OFS_ED  +: LAT_W];
    assign item.horizon_points = s_axis_tdata[OFS_HOR +: HOR_W];
    assign item.is_vehicle     = s_axis_tuser;
    assign item.last_in_frame  = s_axis_tlast;

    lvsg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    lvsg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lvsg_dp #(
        .POSITION_BITS (POSITION_BITS),
        .SPEED_BITS    (SPEED_BITS),
        .HORIZON_MAX   (HORIZON_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_item      (item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = OUT_DATA_W'({res.lead_speed, res.lead_gap, res.ego_speed});
    assign m_axis_tuser = {res.lead_found, res.too_close};

endmodule
